// File: rtl/imu_acc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturation helpers for the acceleration filter/integrator.
package imu_acc_pkg;

    localparam int NUM_AXES    = 3;
    localparam int SAMPLE_W    = 16;
    localparam int SMOOTH_W    = 32;
    localparam int VEL_W       = 40;
    localparam int POS_W       = 48;
    localparam int ADDR_W      = 5;
    localparam int IN_DATA_W   = 3 * SAMPLE_W;
    localparam int OUT_DATA_W  = 3 * SAMPLE_W + 3 * VEL_W + 3 * POS_W;

    // register indexes
    localparam logic [2:0] REG_OFFSET_X  = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z  = 3'd2;
    localparam logic [2:0] REG_STRENGTH  = 3'd3;
    localparam logic [2:0] REG_COEF      = 3'd4;
    localparam logic [2:0] REG_TOLERANCE = 3'd5;
    localparam logic [2:0] REG_TIME_STEP = 3'd6;

    // deadband factors x5 scale: 1.0, 0.8, 0.2
    localparam logic [2:0] AXIS_FACTOR [NUM_AXES] = '{3'd5, 3'd4, 3'd1};

    typedef struct packed {
        logic [15:0] strength;
        logic [15:0] coef;
        logic [14:0] tol;
        logic [15:0] dt;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] g;
        logic signed [VEL_W-1:0]    vel;
        logic signed [POS_W-1:0]    pos;
    } lane_res_t;

    typedef enum logic [2:0] {
        L_IDLE, L_MUL, L_FILT, L_GATE, L_INC, L_VEL, L_PMUL, L_POS
    } lane_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if ((&v[34:31]) || !(|v[34:31])) return v[31:0];
        return v[34] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v[16] == v[15]) return v[15:0];
        return v[16] ? {1'b1, 15'd0} : {1'b0, {15{1'b1}}};
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
        if (v[40] == v[39]) return v[39:0];
        return v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        if (v[48] == v[47]) return v[47:0];
        return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    endfunction

endpackage

// File: rtl/imu_accel_filter_integrator_top.sv
`timescale 1ns / 1ps
// Top level: APB register file, three axis lanes and the output merge stage.
// Each three-axis sample runs through three identical lanes in parallel. After the
// accepting edge the lanes step through multiply, filter, gate, stillness check
// and velocity multiply, velocity, split position multiply and position. The
// finished result sets a registered pending flag and is loaded into the output
// register once it is free; s_tready returns as that load clears the flag, so
// no new sample is accepted before the last result is loaded. A new sample is
// accepted while the previous result still waits in the output register. A
// finished lane result is held, with the input stalled, until the output
// register frees. Registers sit at byte address 4*index; pready is always high.
module imu_accel_filter_integrator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [imu_acc_pkg::IN_DATA_W-1:0] s_tdata,  // sample_x, sample_y, sample_z
    output logic        m_tvalid,
    input  logic        m_tready,
    // gated_x/y/z, speed_x/y/z, place_x/y/z
    output logic [imu_acc_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [imu_acc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [15:0] offset_reg [imu_acc_pkg::NUM_AXES];
    imu_acc_pkg::cfg_t  cfg_reg;
    logic               busy_reg;
    logic               in_xfer, pend;
    logic [imu_acc_pkg::NUM_AXES-1:0] done;
    logic               lanes_done;
    imu_acc_pkg::lane_res_t res [imu_acc_pkg::NUM_AXES];

    assign pready     = 1'b1;
    assign in_xfer    = s_tvalid && s_tready;
    assign s_tready   = !busy_reg && !pend;
    assign lanes_done = &done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg[0]    <= '0;
            offset_reg[1]    <= '0;
            offset_reg[2]    <= '0;
            cfg_reg.strength <= 16'd256;
            cfg_reg.coef     <= 16'd58982;
            cfg_reg.tol      <= 15'd3;
            cfg_reg.dt       <= 16'd655;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                imu_acc_pkg::REG_OFFSET_X:  offset_reg[0]    <= pwdata[15:0];
                imu_acc_pkg::REG_OFFSET_Y:  offset_reg[1]    <= pwdata[15:0];
                imu_acc_pkg::REG_OFFSET_Z:  offset_reg[2]    <= pwdata[15:0];
                imu_acc_pkg::REG_STRENGTH:  cfg_reg.strength <= pwdata[15:0];
                imu_acc_pkg::REG_COEF:      cfg_reg.coef     <= pwdata[15:0];
                imu_acc_pkg::REG_TOLERANCE: cfg_reg.tol      <= pwdata[14:0];
                imu_acc_pkg::REG_TIME_STEP: cfg_reg.dt       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            imu_acc_pkg::REG_OFFSET_X:  prdata = 32'(offset_reg[0]);
            imu_acc_pkg::REG_OFFSET_Y:  prdata = 32'(offset_reg[1]);
            imu_acc_pkg::REG_OFFSET_Z:  prdata = 32'(offset_reg[2]);
            imu_acc_pkg::REG_STRENGTH:  prdata = {16'd0, cfg_reg.strength};
            imu_acc_pkg::REG_COEF:      prdata = {16'd0, cfg_reg.coef};
            imu_acc_pkg::REG_TOLERANCE: prdata = {17'd0, cfg_reg.tol};
            imu_acc_pkg::REG_TIME_STEP: prdata = {16'd0, cfg_reg.dt};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (in_xfer) begin
            busy_reg <= 1'b1;
        end else if (lanes_done) begin
            busy_reg <= 1'b0;
        end
    end

    for (genvar i = 0; i < imu_acc_pkg::NUM_AXES; i++) begin : g_lane
        imu_acc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (in_xfer),
            .raw     (s_tdata[i*imu_acc_pkg::SAMPLE_W +: imu_acc_pkg::SAMPLE_W]),
            .offset  (offset_reg[i]),
            .factor  (imu_acc_pkg::AXIS_FACTOR[i]),
            .cfg     (cfg_reg),
            .done    (done[i]),
            .res     (res[i])
        );
    end

    imu_acc_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .done     (lanes_done),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .pend     (pend)
    );

endmodule

// File: rtl/imu_acc_lane.sv
`timescale 1ns / 1ps
// One axis: low-pass filter, deadband gate and trapezoidal integration sequencer.
module imu_acc_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [15:0]    raw,
    input  logic signed [15:0]    offset,
    input  logic [2:0]            factor,
    input  imu_acc_pkg::cfg_t     cfg,
    output logic                  done,
    output imu_acc_pkg::lane_res_t res
);

    imu_acc_pkg::lane_state_t state_reg, state_next;

    logic signed [15:0] raw_reg;
    logic signed [31:0] s_reg;
    logic signed [15:0] g_reg, gp_reg;
    logic signed [39:0] vel_reg, vb_reg;
    logic signed [47:0] pos_reg;
    logic signed [48:0] ks_prod_reg;
    logic signed [33:0] kr_prod_reg;
    logic [32:0]        gate_prod_reg;
    logic               pass_reg;
    logic signed [33:0] inc_prod_reg;
    logic signed [40:0] sumv_reg;
    logic [39:0]        lo_prod_reg;
    logic signed [33:0] hi_prod_reg;

    logic [16:0]        mag_raw, mag_off, mag_g;
    logic signed [50:0] filt_sum;
    logic [35:0]        gate_lim;
    logic [27:0]        raw_lim;
    logic signed [32:0] g_sum;
    logic signed [16:0] g_pair;
    logic signed [34:0] inc_sum;
    logic signed [40:0] vel_sum;
    logic signed [58:0] pos_full;
    logic signed [41:0] pos_inc;
    logic signed [15:0] g_new;

    assign mag_raw  = raw_reg[15] ? 17'(-$signed({raw_reg[15], raw_reg})) : {1'b0, raw_reg};
    assign mag_off  = offset[15] ? 17'(-$signed({offset[15], offset})) : {1'b0, offset};
    assign mag_g    = g_reg[15] ? 17'(-$signed({g_reg[15], g_reg})) : {1'b0, g_reg};
    assign filt_sum = 51'(ks_prod_reg) + (51'(kr_prod_reg) <<< 16) + 51'sd32768;
    assign gate_lim = 36'(gate_prod_reg) * 36'(factor);
    assign raw_lim  = 28'(mag_raw) * 28'd1280;
    assign g_sum    = 33'(s_reg) + 33'sd32768;
    assign g_new    = imu_acc_pkg::sat16(17'(g_sum >>> 16));
    assign g_pair   = 17'(gp_reg) + 17'(g_reg);
    assign inc_sum  = 35'(inc_prod_reg) + 35'sd1;
    assign vel_sum  = 41'(vb_reg) + 41'(34'(inc_sum >>> 1));
    assign pos_full = (59'(hi_prod_reg) <<< 24) + $signed({19'd0, lo_prod_reg});
    assign pos_inc  = 42'((pos_full + 59'sd65536) >>> 17);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imu_acc_pkg::L_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            imu_acc_pkg::L_IDLE: if (start) state_next = imu_acc_pkg::L_MUL;
            imu_acc_pkg::L_MUL:  state_next = imu_acc_pkg::L_FILT;
            imu_acc_pkg::L_FILT: state_next = imu_acc_pkg::L_GATE;
            imu_acc_pkg::L_GATE: state_next = imu_acc_pkg::L_INC;
            imu_acc_pkg::L_INC:  state_next = imu_acc_pkg::L_VEL;
            imu_acc_pkg::L_VEL:  state_next = imu_acc_pkg::L_PMUL;
            imu_acc_pkg::L_PMUL: state_next = imu_acc_pkg::L_POS;
            imu_acc_pkg::L_POS: begin
                state_next = imu_acc_pkg::L_IDLE;
                done       = 1'b1;
            end
            default: state_next = imu_acc_pkg::L_IDLE;
        endcase
    end

    // filter and integrator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg   <= '0;
            gp_reg  <= '0;
            g_reg   <= '0;
            vel_reg <= '0;
            pos_reg <= '0;
        end else begin
            case (state_reg)
                imu_acc_pkg::L_FILT: s_reg <= imu_acc_pkg::sat32(35'(filt_sum >>> 16));
                imu_acc_pkg::L_GATE: g_reg <= pass_reg ? g_new : '0;
                imu_acc_pkg::L_VEL:  vel_reg <= imu_acc_pkg::sat40(vel_sum);
                imu_acc_pkg::L_POS: begin
                    pos_reg <= imu_acc_pkg::sat48(49'(pos_reg) + 49'(pos_inc));
                    gp_reg  <= g_reg;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (state_reg == imu_acc_pkg::L_IDLE && start) raw_reg <= raw;
        case (state_reg)
            imu_acc_pkg::L_MUL: begin
                ks_prod_reg   <= $signed({1'b0, cfg.coef}) * s_reg;
                kr_prod_reg   <= $signed(18'h10000 - {2'b0, cfg.coef}) * raw_reg;
                gate_prod_reg <= mag_off * cfg.strength;
            end
            imu_acc_pkg::L_FILT: pass_reg <= {8'd0, raw_lim} >= gate_lim;
            imu_acc_pkg::L_INC: begin
                vb_reg       <= (mag_g < {2'b0, cfg.tol}) ? '0 : vel_reg;
                inc_prod_reg <= $signed({1'b0, cfg.dt}) * g_pair;
            end
            imu_acc_pkg::L_VEL: sumv_reg <= 41'(vb_reg) + 41'(imu_acc_pkg::sat40(vel_sum));
            imu_acc_pkg::L_PMUL: begin
                lo_prod_reg <= cfg.dt * sumv_reg[23:0];
                hi_prod_reg <= $signed({1'b0, cfg.dt}) * $signed(sumv_reg[40:24]);
            end
            default: ;
        endcase
    end

    assign res.g   = g_reg;
    assign res.vel = vel_reg;
    assign res.pos = pos_reg;

endmodule

// File: rtl/imu_acc_merge.sv
`timescale 1ns / 1ps
// Merge stage: collects the three lane results into the output register.
module imu_acc_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          done,
    input  imu_acc_pkg::lane_res_t        res [imu_acc_pkg::NUM_AXES],
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [imu_acc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                          pend
);

    logic pend_reg, valid_reg, load;
    logic [imu_acc_pkg::OUT_DATA_W-1:0] data_reg;

    assign load = pend_reg && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (done) pend_reg <= 1'b1;
            else if (load) pend_reg <= 1'b0;
            if (load) valid_reg <= 1'b1;
            else if (m_tready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {res[2].pos, res[1].pos, res[0].pos,
                         res[2].vel, res[1].vel, res[0].vel,
                         res[2].g, res[1].g, res[0].g};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign pend     = pend_reg;

endmodule

// File: rtl/imu_acc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the filter/integrator top, bound to the top level.
module imu_acc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [imu_acc_pkg::OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transfer dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while lanes busy");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without lane latency");

endmodule

bind imu_accel_filter_integrator_top imu_acc_checker u_imu_acc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for the acceleration filter/integrator: predicted results checked per transfer.
module testbench;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [imu_acc_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [imu_acc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [imu_acc_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    imu_accel_filter_integrator_top dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state and configuration
    longint offs [3];
    longint strength, coef, tolerance, dt;
    longint smooth [3];
    longint prev_g [3];
    longint vel [3];
    longint pos [3];

    logic [imu_acc_pkg::OUT_DATA_W-1:0] expected_results [$];
    int errors = 0;
    longint cycles = 0;
    bit stall_hold = 1'b0;
    int stall_mode = 0;

    function automatic longint sat_w(longint v, int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [imu_acc_pkg::OUT_DATA_W-1:0] predict_motion(
        logic [imu_acc_pkg::IN_DATA_W-1:0] smp);
        logic [imu_acc_pkg::SAMPLE_W-1:0] gq [3];
        logic [imu_acc_pkg::VEL_W-1:0] vq [3];
        logic [imu_acc_pkg::POS_W-1:0] pq [3];
        longint raw, tgt, s, g, v, vn, inc;
        longint fac [3];
        fac = '{5, 4, 1};
        for (int i = 0; i < 3; i++) begin
            raw = longint'($signed(smp[i*imu_acc_pkg::SAMPLE_W +: imu_acc_pkg::SAMPLE_W]));
            tgt = sat_w(raw * 65536, imu_acc_pkg::SMOOTH_W);
            s = sat_w(rnd_shift(coef * smooth[i] + (65536 - coef) * tgt, 16),
                      imu_acc_pkg::SMOOTH_W);
            smooth[i] = s;
            g = sat_w(rnd_shift(s, 16), imu_acc_pkg::SAMPLE_W);
            if (absl(raw) * 1280 < absl(offs[i]) * strength * fac[i]) g = 0;
            v = vel[i];
            if (absl(g) < tolerance) v = 0;
            inc = rnd_shift(dt * (prev_g[i] + g), 1);
            vn = sat_w(v + inc, imu_acc_pkg::VEL_W);
            pos[i] = sat_w(pos[i] + rnd_shift(dt * (v + vn), 17), imu_acc_pkg::POS_W);
            vel[i] = vn;
            prev_g[i] = g;
            gq[i] = g[imu_acc_pkg::SAMPLE_W-1:0];
            vq[i] = vn[imu_acc_pkg::VEL_W-1:0];
            pq[i] = pos[i][imu_acc_pkg::POS_W-1:0];
        end
        return {pq[2], pq[1], pq[0], vq[2], vq[1], vq[0], gq[2], gq[1], gq[0]};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= imu_acc_pkg::ADDR_W'(idx) << 2; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            imu_acc_pkg::REG_OFFSET_X:  offs[0] = longint'($signed(value[15:0]));
            imu_acc_pkg::REG_OFFSET_Y:  offs[1] = longint'($signed(value[15:0]));
            imu_acc_pkg::REG_OFFSET_Z:  offs[2] = longint'($signed(value[15:0]));
            imu_acc_pkg::REG_STRENGTH:  strength = value[15:0];
            imu_acc_pkg::REG_COEF:      coef = value[15:0];
            imu_acc_pkg::REG_TOLERANCE: tolerance = value[14:0];
            imu_acc_pkg::REG_TIME_STEP: dt = value[15:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(logic [imu_acc_pkg::IN_DATA_W-1:0] smp);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_motion(smp));
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // bursts of random length separated by random gaps
    int burst_left = 0;
    task automatic send_paced(logic [imu_acc_pkg::IN_DATA_W-1:0] smp);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 20)) @(negedge aclk);
        end
        burst_left--;
        send_sample(smp);
    endtask

    task automatic drain;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_field(int kind);
        case (kind)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 60)) - 16'd30;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [imu_acc_pkg::IN_DATA_W-1:0] rand_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return {16'($urandom), 16'($urandom), 16'($urandom)};
        return {rand_field($urandom_range(0, 3)), rand_field($urandom_range(0, 3)),
                rand_field($urandom_range(0, 3))};
    endfunction

    task automatic test_directed;
        send_sample({16'h7FFF, 16'h7FFF, 16'h7FFF});
        send_sample({16'h8000, 16'h8000, 16'h8000});
        send_sample('0);
        send_sample({16'h0001, 16'hFFFF, 16'h0002});
        drain();
        // gate thresholds around the offsets, and zero smoothing
        write_reg(imu_acc_pkg::REG_OFFSET_X, 32'd100);
        write_reg(imu_acc_pkg::REG_OFFSET_Y, 32'hFFFF_FF9C);
        write_reg(imu_acc_pkg::REG_OFFSET_Z, 32'd400);
        write_reg(imu_acc_pkg::REG_COEF, 32'd0);
        send_sample({16'd80, 16'd80, 16'd100});
        send_sample({16'd79, 16'd79, 16'd99});
        send_sample({16'hFF9C, 16'hFFB0, 16'hFF9C});
        send_sample({16'hFF9D, 16'hFFB1, 16'hFF9D});
        drain();
        // zero time step: position holds, and velocity holds or is cleared by the stillness check
        write_reg(imu_acc_pkg::REG_TIME_STEP, 32'd0);
        write_reg(imu_acc_pkg::REG_TOLERANCE, 32'h7FFF);
        for (int i = 0; i < 4; i++) send_sample({16'h4000, 16'h8000, 16'h7FFF});
        drain();
        // saturation: largest step and coefficient, strong input
        write_reg(imu_acc_pkg::REG_TIME_STEP, 32'hFFFF);
        write_reg(imu_acc_pkg::REG_TOLERANCE, 32'd0);
        write_reg(imu_acc_pkg::REG_COEF, 32'hFFFF);
        write_reg(imu_acc_pkg::REG_STRENGTH, 32'hFFFF);
        write_reg(imu_acc_pkg::REG_OFFSET_X, 32'h8000);
        for (int i = 0; i < 6; i++) send_sample({16'h7FFF, 16'h8000, 16'h7FFF});
        drain();
        // unknown register index: nothing changes
        write_reg(3'd7, 32'h1234);
        send_sample({16'h7FFF, 16'h8000, 16'h7FFF});
        drain();
    endtask

    task automatic test_random_settings;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(imu_acc_pkg::REG_OFFSET_X, $urandom);
            write_reg(imu_acc_pkg::REG_OFFSET_Y, $urandom_range(0, 400));
            write_reg(imu_acc_pkg::REG_OFFSET_Z, $urandom);
            write_reg(imu_acc_pkg::REG_STRENGTH, ph[0] ? $urandom : $urandom_range(0, 512));
            write_reg(imu_acc_pkg::REG_COEF, ph == 5 ? 32'd0 : $urandom);
            write_reg(imu_acc_pkg::REG_TOLERANCE, $urandom_range(0, 40));
            write_reg(imu_acc_pkg::REG_TIME_STEP, ph == 4 ? 32'hFFFF : $urandom);
            stall_mode = ph % 3;
            for (int i = 0; i < 160; i++) send_paced(rand_sample());
            drain();
        end
        write_reg(imu_acc_pkg::REG_STRENGTH, 32'd0);
        write_reg(imu_acc_pkg::REG_TIME_STEP, 32'd1);
        for (int i = 0; i < 30; i++) send_paced(rand_sample());
        drain();
    endtask

    task automatic test_backpressure;
        stall_hold = 1'b1;
        for (int i = 0; i < 40; i++) send_sample(rand_sample());
        // pause the sender until everything has come out
        wait (expected_results.size() == 0);
        for (int i = 0; i < 20; i++) send_paced(rand_sample());
        drain();
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(negedge aclk) begin
        if (stall_hold) begin
            m_tready <= 1'b0;
            repeat (400) @(negedge aclk);
            stall_hold = 1'b0;
        end else case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (cycles % 37) > 20;
        endcase
    end

    always @(posedge aclk) begin
        logic [imu_acc_pkg::OUT_DATA_W-1:0] want;
        cycles++;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (m_tdata[i*16 +: 16] !== want[i*16 +: 16]) begin
                        $display("%0t: gated axis %0d expected %h actual %h", $time, i,
                                 want[i*16 +: 16], m_tdata[i*16 +: 16]);
                        errors++;
                    end
                    if (m_tdata[48 + i*40 +: 40] !== want[48 + i*40 +: 40]) begin
                        $display("%0t: speed axis %0d expected %h actual %h", $time, i,
                                 want[48 + i*40 +: 40], m_tdata[48 + i*40 +: 40]);
                        errors++;
                    end
                    if (m_tdata[168 + i*48 +: 48] !== want[168 + i*48 +: 48]) begin
                        $display("%0t: place axis %0d expected %h actual %h", $time, i,
                                 want[168 + i*48 +: 48], m_tdata[168 + i*48 +: 48]);
                        errors++;
                    end
                end
            end
        end
        if (cycles > 400000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        offs = '{0, 0, 0};
        smooth = '{0, 0, 0};
        prev_g = '{0, 0, 0};
        vel = '{0, 0, 0};
        pos = '{0, 0, 0};
        strength = 256; coef = 58982; tolerance = 3; dt = 655;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_settings();
        test_backpressure();
        if (errors == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/imu_acc_pkg.sv
rtl/imu_acc_lane.sv
rtl/imu_acc_merge.sv
rtl/imu_accel_filter_integrator_top.sv
rtl/imu_acc_checker.sv
sim/testbench.sv
